// ===== sv/spr_pkg.sv =====
// Shared types and constants for the spectral peak refinement block.
// Used by the frame store, the offset divider, the top level and the checker.
`default_nettype none

package spr_pkg;

   localparam int MAG_W  = 24;
   localparam int PH_W   = 16;
   localparam int PHO_W  = 17;
   localparam int OFF_W  = 16;
   localparam int THR_W  = 16;
   localparam int BIN_W  = 10;
   localparam int WORD_W = MAG_W + PH_W;

   localparam logic [THR_W-1:0] THR_MIN   = 16'd66;
   localparam logic [THR_W-1:0] THR_MAX   = 16'd32768;
   localparam logic [THR_W-1:0] THR_RESET = 16'd655;

   localparam logic [MAG_W-1:0] MAG_MAX   = 24'hFFFFFF;
   localparam logic [PHO_W-1:0] PH17_MAX  = 17'h0FFFF;
   localparam logic [PHO_W-1:0] PH17_MIN  = 17'h10000;
   localparam logic [14:0]      OFF_LIMIT = 15'd16384;

   // Offset divider: the quotient never exceeds 16384, so 15 quotient bits suffice.
   localparam int DIV_NUM_W = 40;
   localparam int DIV_DEN_W = 26;
   localparam int DIV_Q_W   = 15;
   localparam int DIV_CNT_W = 4;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_B,
      ST_RD_A,
      ST_RD_G,
      ST_MUL_THR,
      ST_CHECK,
      ST_DIV,
      ST_MUL_MAG,
      ST_MAG,
      ST_MUL_PH,
      ST_PH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== sv/spectral_peak_parabolic_refine.sv =====
// Spectral peak refinement top level: sequencer, shared multiplier and result register.
// Uses spr_pkg, spr_store and spr_div.
`default_nettype none

// Write words store one bin's magnitude and phase in an on-chip frame store and
// track the frame maximum (a write to bin 0 starts a new frame); writes to bins
// past FFT_SIZE/2 are dropped. A read word returns one result word: bins strictly
// inside the frame that beat both neighbours and the threshold fraction of the
// frame maximum get a parabolic sub-bin offset (Q1.15), a refined magnitude and a
// linearly interpolated phase (Q4.13, not wrapped); other bins pass through with
// offset zero, and out-of-range bins return zeros. A read works through the three
// store reads, the bit-serial offset divider and the single shared multiplier, as
// far as its bin needs them. One item is in work at a time, and a finished result
// waits in the output register while the next item is taken; a read's last cycle
// is held until the previous result word has left. Reading a bin, or a neighbour
// of it, that was never written gives undefined data.
module spectral_peak_parabolic_refine
   import spr_pkg::*;
#(
   parameter int FFT_SIZE = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_action,
   input  wire logic        [BIN_W-1:0]  req_bin_index,
   input  wire logic        [MAG_W-1:0]  req_magnitude,
   input  wire logic signed [PH_W-1:0]   req_phase,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic             [BIN_W-1:0]  rsp_result_bin,
   output logic                          rsp_is_peak,
   output logic signed      [OFF_W-1:0]  rsp_bin_offset,
   output logic             [MAG_W-1:0]  rsp_refined_magnitude,
   output logic signed      [PHO_W-1:0]  rsp_refined_phase,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic        [THR_W-1:0]  csr_peak_threshold
);

   localparam int NUM_BINS = FFT_SIZE / 2 + 1;
   localparam int ADDR_W   = $clog2(NUM_BINS);

   state_type state_ff, state_in;

   // control registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic              in_range_ff, interior_ff, peak_ff;
   logic [MAG_W-1:0]  max_ff;
   logic [THR_W-1:0]  thr_ff, thr_in;

   // working registers of the item in flight
   logic        [BIN_W-1:0]  k_ff;
   logic        [MAG_W-1:0]  b_ff, a_ff, g_ff;
   logic signed [PH_W-1:0]   pk_ff, pn_ff;
   logic signed [41:0]       prod_ff;
   logic signed [OFF_W-1:0]  off_ff;
   logic        [MAG_W-1:0]  mag_ff;
   logic signed [PHO_W-1:0]  ph_ff;

   // result register
   logic        [BIN_W-1:0]  rsp_bin_ff;
   logic                     rsp_peak_ff;
   logic signed [OFF_W-1:0]  rsp_off_ff;
   logic        [MAG_W-1:0]  rsp_mag_ff;
   logic signed [PHO_W-1:0]  rsp_ph_ff;

   logic              req_fire, req_in_range, rsp_load, peak_cond, div_start;
   logic [31:0]       req_k_ext, k_ext, raddr_ext;
   store_ctl_type     store_ctl;
   logic [WORD_W-1:0] rdata;
   div_status_type    div_status;
   logic [DIV_Q_W-1:0] div_q;

   logic signed [24:0]     gma;
   logic signed [PHO_W-1:0] dp;
   logic signed [24:0]     mul_x;
   logic signed [16:0]     mul_y;
   logic signed [41:0]     mul_p;
   logic [23:0]            absd;
   logic [24:0]            den_d;
   logic [DIV_NUM_W-1:0]   div_num;
   logic [DIV_DEN_W-1:0]   div_den;
   logic [DIV_Q_W-1:0]     q_clamp;
   logic signed [OFF_W-1:0] off_val;
   logic [40:0]            term;
   logic [41:0]            tsum;
   logic [25:0]            msum;
   logic [MAG_W-1:0]       mag_val;
   logic [41:0]            pabs;
   logic [42:0]            psum;
   logic [17:0]            pq;
   logic signed [18:0]     pqs, phs;
   logic signed [PHO_W-1:0] ph_val;

   assign req_k_ext    = 32'(req_bin_index);
   assign k_ext        = 32'(k_ff);
   assign req_in_range = req_k_ext < 32'(NUM_BINS);
   assign req_fire     = req_valid && req_ready;
   assign csr_ready    = 1'b1;

   // ---------------- frame store ----------------
   always_comb begin
      case (state_ff)
         ST_RD_A: raddr_ext = k_ext - 32'd1;
         ST_RD_G: raddr_ext = k_ext + 32'd1;
         default: raddr_ext = k_ext;
      endcase
   end

   spr_store #(
      .DEPTH  (NUM_BINS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .ctl   (store_ctl),
      .waddr (req_k_ext[ADDR_W-1:0]),
      .wdata ({req_magnitude, req_phase}),
      .raddr (raddr_ext[ADDR_W-1:0]),
      .rdata (rdata)
   );

   // ---------------- offset divider ----------------
   assign gma   = $signed({1'b0, g_ff}) - $signed({1'b0, a_ff});
   assign absd  = gma[24] ? 24'(-gma) : gma[23:0];
   assign den_d = {b_ff, 1'b0} - {1'b0, a_ff} - {1'b0, g_ff};
   // Rounded to nearest: floor((2|n| + d) / 2d) with n = (g - a) * 16384.
   assign div_num = {1'b0, absd, 15'b0} + {15'b0, den_d};
   assign div_den = {den_d, 1'b0};

   spr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .status   (div_status),
      .quotient (div_q)
   );

   assign q_clamp = (div_q > OFF_LIMIT) ? OFF_LIMIT : div_q;
   assign off_val = gma[24] ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});

   // ---------------- shared multiplier ----------------
   assign dp = $signed({pn_ff[PH_W-1], pn_ff}) - $signed({pk_ff[PH_W-1], pk_ff});

   always_comb begin
      case (state_ff)
         ST_MUL_THR: begin
            mul_x = $signed({1'b0, max_ff});
            mul_y = $signed({1'b0, thr_ff});
         end
         ST_MUL_MAG: begin
            mul_x = gma;
            mul_y = $signed({off_ff[OFF_W-1], off_ff});
         end
         default: begin
            mul_x = $signed({{8{dp[PHO_W-1]}}, dp});
            mul_y = $signed({off_ff[OFF_W-1], off_ff});
         end
      endcase
   end

   assign mul_p = mul_x * mul_y;

   // The threshold product sits in prod_ff while the peak test runs.
   assign peak_cond = (b_ff > a_ff) && (b_ff > g_ff) && ({b_ff, 16'h0000} > prod_ff[39:0]);

   // ---------------- magnitude refinement ----------------
   // (g - a) and the offset share a sign, so the product is never negative.
   assign term    = prod_ff[41] ? '0 : prod_ff[40:0];
   assign tsum    = {1'b0, term} + 42'd65536;
   assign msum    = {2'b00, b_ff} + {1'b0, tsum[41:17]};
   assign mag_val = (msum[25:24] != 2'b00) ? MAG_MAX : msum[23:0];

   // ---------------- phase interpolation ----------------
   assign pabs   = prod_ff[41] ? 42'(-prod_ff) : prod_ff;
   assign psum   = {1'b0, pabs} + 43'd16384;
   assign pq     = psum[32:15];
   assign pqs    = prod_ff[41] ? -$signed({1'b0, pq}) : $signed({1'b0, pq});
   assign phs    = $signed({{3{pk_ff[PH_W-1]}}, pk_ff}) + pqs;

   always_comb begin
      if ((phs[18:16] == 3'b000) || (phs[18:16] == 3'b111)) begin
         ph_val = phs[PHO_W-1:0];
      end else if (phs[18]) begin
         ph_val = PH17_MIN;
      end else begin
         ph_val = PH17_MAX;
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_action == ACT_READ)) begin
               state_in = req_in_range ? ST_RD_B : ST_DONE;
            end
         end
         ST_RD_B:    state_in = ST_RD_A;
         ST_RD_A:    state_in = interior_ff ? ST_RD_G : ST_DONE;
         ST_RD_G:    state_in = ST_MUL_THR;
         ST_MUL_THR: state_in = ST_CHECK;
         ST_CHECK:   state_in = peak_cond ? ST_DIV : ST_DONE;
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_MUL_MAG;
            end
         end
         ST_MUL_MAG: state_in = ST_MAG;
         ST_MAG:     state_in = ST_MUL_PH;
         ST_MUL_PH:  state_in = ST_PH;
         ST_PH:      state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      store_ctl.wr_en = 1'b0;
      store_ctl.rd_en = 1'b0;
      div_start       = 1'b0;
      rsp_load        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            store_ctl.wr_en = req_valid && (req_action == ACT_WRITE) && req_in_range;
         end
         ST_RD_B:  store_ctl.rd_en = 1'b1;
         ST_RD_A:  store_ctl.rd_en = interior_ff;
         ST_RD_G:  store_ctl.rd_en = 1'b1;
         ST_CHECK: div_start       = peak_cond;
         ST_DONE:  rsp_load        = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   // ---------------- registers ----------------
   always_comb begin
      thr_in = csr_peak_threshold;
      if (csr_peak_threshold < THR_MIN) begin
         thr_in = THR_MIN;
      end else if (csr_peak_threshold > THR_MAX) begin
         thr_in = THR_MAX;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_ff       <= '0;
         thr_ff       <= THR_RESET;
         in_range_ff  <= 1'b0;
         interior_ff  <= 1'b0;
         peak_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= thr_in;
         end
         if (store_ctl.wr_en) begin
            if ((req_bin_index == '0) || (req_magnitude > max_ff)) begin
               max_ff <= req_magnitude;
            end
         end
         if (req_fire && (req_action == ACT_READ)) begin
            in_range_ff <= req_in_range;
            interior_ff <= (req_bin_index != '0) && (req_k_ext < 32'(NUM_BINS - 1));
            peak_ff     <= 1'b0;
         end else if (state_ff == ST_CHECK) begin
            peak_ff <= peak_cond;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         k_ff <= req_bin_index;
      end
      case (state_ff)
         ST_RD_A: begin
            b_ff  <= rdata[WORD_W-1:PH_W];
            pk_ff <= rdata[PH_W-1:0];
         end
         ST_RD_G: a_ff <= rdata[WORD_W-1:PH_W];
         ST_MUL_THR: begin
            g_ff    <= rdata[WORD_W-1:PH_W];
            pn_ff   <= rdata[PH_W-1:0];
            prod_ff <= mul_p;
         end
         ST_DIV: begin
            if (div_status.done) begin
               off_ff <= off_val;
            end
         end
         ST_MUL_MAG: prod_ff <= mul_p;
         ST_MAG:     mag_ff  <= mag_val;
         ST_MUL_PH:  prod_ff <= mul_p;
         ST_PH:      ph_ff   <= ph_val;
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_bin_ff  <= k_ff;
         rsp_peak_ff <= peak_ff;
         if (!in_range_ff) begin
            rsp_off_ff <= '0;
            rsp_mag_ff <= '0;
            rsp_ph_ff  <= '0;
         end else if (peak_ff) begin
            rsp_off_ff <= off_ff;
            rsp_mag_ff <= mag_ff;
            rsp_ph_ff  <= ph_ff;
         end else begin
            rsp_off_ff <= '0;
            rsp_mag_ff <= b_ff;
            rsp_ph_ff  <= $signed({pk_ff[PH_W-1], pk_ff});
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_bin        = rsp_bin_ff;
   assign rsp_is_peak           = rsp_peak_ff;
   assign rsp_bin_offset        = rsp_off_ff;
   assign rsp_refined_magnitude = rsp_mag_ff;
   assign rsp_refined_phase     = rsp_ph_ff;

endmodule

`default_nettype wire

// ===== sv/spr_store.sv =====
// Frame store: one synchronous memory holding magnitude and phase of each bin.
// Uses spr_pkg for the word width and the control struct.
`default_nettype none

module spr_store
   import spr_pkg::*;
#(
   parameter int DEPTH  = 513,
   parameter int ADDR_W = 10
) (
   input  wire logic                clock,
   input  wire store_ctl_type       ctl,
   input  wire logic [ADDR_W-1:0]   waddr,
   input  wire logic [WORD_W-1:0]   wdata,
   input  wire logic [ADDR_W-1:0]   raddr,
   output logic      [WORD_W-1:0]   rdata
);

   logic [WORD_W-1:0] store_mem [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rdata_ff <= store_mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/spr_div.sv =====
// Iterative restoring divider for the sub-bin offset, one quotient bit per cycle.
// Uses spr_pkg for its widths and the status struct.
`default_nettype none

module spr_div
   import spr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIV_NUM_W-1:0]  num,
   input  wire logic [DIV_DEN_W-1:0]  den,
   output div_status_type             status,
   output logic      [DIV_Q_W-1:0]    quotient
);

   logic [DIV_NUM_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] dsh_ff, dsh_in;
   logic [DIV_Q_W-1:0]   q_ff, q_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 fits;

   assign fits = rem_ff >= dsh_ff;

   // The caller guarantees num < den * 2**DIV_Q_W, so the divisor starts
   // aligned to the top quotient bit and shifts right one place per step.
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         dsh_in  = DIV_NUM_W'(den) << (DIV_Q_W - 1);
         q_in    = '0;
         cnt_in  = DIV_CNT_W'(DIV_Q_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_ff - dsh_ff) : rem_ff;
         q_in   = {q_ff[DIV_Q_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule

`default_nettype wire

// ===== sv/spr_checker.sv =====
// Port-level checks for the spectral peak refinement block, bound to its top level.
// Uses spr_pkg for field widths.
`default_nettype none

module spr_checker
   import spr_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic        [BIN_W-1:0]  rsp_result_bin,
   input wire logic                     rsp_is_peak,
   input wire logic signed [OFF_W-1:0]  rsp_bin_offset,
   input wire logic        [MAG_W-1:0]  rsp_refined_magnitude
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_offset_zero_off_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_peak) |-> (rsp_bin_offset == '0))
      else $error("non-peak word carries a nonzero offset");

   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_bin_offset <= 16'sd16384) && (rsp_bin_offset >= -16'sd16384)))
      else $error("offset outside half a bin");

   a_edge_bin_no_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_bin == '0)) |-> !rsp_is_peak)
      else $error("bin zero reported as a peak");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_refined_magnitude)))
      else $error("stalled result word changed");

endmodule

bind spectral_peak_parabolic_refine spr_checker u_spr_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_result_bin        (rsp_result_bin),
   .rsp_is_peak           (rsp_is_peak),
   .rsp_bin_offset        (rsp_bin_offset),
   .rsp_refined_magnitude (rsp_refined_magnitude)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for spectral_peak_parabolic_refine: drives write and read words,
// predicts every refined result in-line and compares it field by field as it comes out.
// Depends on spr_pkg and the spectral_peak_parabolic_refine top level only.

module testbench;
   import spr_pkg::*;

   localparam int     FFT_POINTS    = 1024;
   localparam int     BIN_COUNT     = FFT_POINTS / 2 + 1;
   localparam longint MAG_CEIL      = 16777215;
   localparam longint PHASE_HI      = 65535;
   localparam longint PHASE_LO      = -65536;
   localparam longint OFFSET_CLAMP  = 16384;
   localparam int     SETTLE_CYCLES = 40;
   localparam int     CYCLE_LIMIT   = 600000;
   localparam int     PRINT_LIMIT   = 100;

   typedef enum int unsigned {MAG_FULL, MAG_TINY, MAG_TOP, MAG_SCALED} mag_style_type;

   typedef struct packed {
      logic [BIN_W-1:0] bin;
      logic             is_peak;
      logic [OFF_W-1:0] offset;
      logic [MAG_W-1:0] magnitude;
      logic [PHO_W-1:0] phase;
   } refined_bin_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_action = ACT_WRITE;
   logic        [BIN_W-1:0] req_bin_index = '0;
   logic        [MAG_W-1:0] req_magnitude = '0;
   logic signed [PH_W-1:0]  req_phase = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic        [BIN_W-1:0] rsp_result_bin;
   logic                    rsp_is_peak;
   logic signed [OFF_W-1:0] rsp_bin_offset;
   logic        [MAG_W-1:0] rsp_refined_magnitude;
   logic signed [PHO_W-1:0] rsp_refined_phase;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic        [THR_W-1:0] csr_peak_threshold = '0;

   // Shadow of the frame store, the running maximum and the threshold register.
   logic        [MAG_W-1:0] mag_mem [BIN_COUNT];
   logic signed [PH_W-1:0]  ph_mem [BIN_COUNT];
   bit                      written [BIN_COUNT];
   logic        [MAG_W-1:0] frame_max = '0;
   logic        [THR_W-1:0] threshold_now = THR_RESET;

   refined_bin_type pending_results[$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           stall_left = 0;
   bit           req_fast = 1'b0;
   bit           rsp_fast = 1'b0;

   spectral_peak_parabolic_refine #(
      .FFT_SIZE(FFT_POINTS)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_bin_index         (req_bin_index),
      .req_magnitude         (req_magnitude),
      .req_phase             (req_phase),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_bin        (rsp_result_bin),
      .rsp_is_peak           (rsp_is_peak),
      .rsp_bin_offset        (rsp_bin_offset),
      .rsp_refined_magnitude (rsp_refined_magnitude),
      .rsp_refined_phase     (rsp_refined_phase),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_peak_threshold    (csr_peak_threshold)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL spectral_peak_parabolic_refine");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // Rounds n/d to nearest with ties away from zero; d is positive.
   function automatic longint round_div(input longint n, input longint d);
      longint m;
      longint q;
      m = (n < 0) ? -n : n;
      q = (2 * m + d) / (2 * d);
      return (n < 0) ? -q : q;
   endfunction

   // Updates the shadow store for a write word, or queues the refined result of a read.
   function automatic void predict_refinement(input logic act, input logic [BIN_W-1:0] bin,
                                              input logic [MAG_W-1:0] mag,
                                              input logic signed [PH_W-1:0] ph);
      refined_bin_type r;
      int           k;
      longint       b, a, g, pk, pn, den, off, term, m, p;
      bit           peak;
      k = int'(bin);
      if (act == ACT_WRITE) begin
         if (k < BIN_COUNT) begin
            mag_mem[k] = mag;
            ph_mem[k] = ph;
            written[k] = 1'b1;
            if (k == 0 || mag > frame_max)
               frame_max = mag;
         end
         return;
      end
      r = '0;
      r.bin = bin;
      if (k < BIN_COUNT) begin
         b = longint'(mag_mem[k]);
         pk = longint'(ph_mem[k]);
         peak = 1'b0;
         if (k >= 1 && k + 1 < BIN_COUNT) begin
            a = longint'(mag_mem[k-1]);
            g = longint'(mag_mem[k+1]);
            peak = b > a && b > g &&
                   (b << 16) > longint'(frame_max) * longint'(threshold_now);
         end
         if (!peak) begin
            r.magnitude = b[MAG_W-1:0];
            r.phase = pk[PHO_W-1:0];
         end else begin
            den = 2 * b - a - g;
            off = round_div((g - a) * 16384, den);
            if (off > OFFSET_CLAMP) off = OFFSET_CLAMP;
            if (off < -OFFSET_CLAMP) off = -OFFSET_CLAMP;
            // The offset always leans toward the larger neighbour, so this term is not negative.
            term = (g - a) * off;
            if (term < 0) term = 0;
            m = b + (term + 65536) / 131072;
            if (m > MAG_CEIL) m = MAG_CEIL;
            pn = longint'(ph_mem[k+1]);
            p = pk + round_div(off * (pn - pk), 32768);
            if (p > PHASE_HI) p = PHASE_HI;
            if (p < PHASE_LO) p = PHASE_LO;
            r.is_peak = 1'b1;
            r.offset = off[OFF_W-1:0];
            r.magnitude = m[MAG_W-1:0];
            r.phase = p[PHO_W-1:0];
         end
      end
      pending_results.insert(pending_results.size(), r);
   endfunction

   // Result side: random stalls per word, with stretches of no stalling.
   always @(posedge clock) begin
      refined_bin_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result word for bin %0d", rsp_result_bin));
            end else begin
               want = pending_results.pop_front();
               if (rsp_result_bin !== want.bin)
                  report_mismatch($sformatf("result_bin got %h want %h",
                                            rsp_result_bin, want.bin));
               if (rsp_is_peak !== want.is_peak)
                  report_mismatch($sformatf("bin %0d is_peak got %b want %b",
                                            want.bin, rsp_is_peak, want.is_peak));
               if (rsp_bin_offset !== want.offset)
                  report_mismatch($sformatf("bin %0d bin_offset got %h want %h",
                                            want.bin, rsp_bin_offset, want.offset));
               if (rsp_refined_magnitude !== want.magnitude)
                  report_mismatch($sformatf("bin %0d refined_magnitude got %h want %h",
                                            want.bin, rsp_refined_magnitude, want.magnitude));
               if (rsp_refined_phase !== want.phase)
                  report_mismatch($sformatf("bin %0d refined_phase got %h want %h",
                                            want.bin, rsp_refined_phase, want.phase));
            end
            if ($urandom_range(0, 49) == 0)
               rsp_fast = !rsp_fast;
            stall_left = rsp_fast ? 0 : $urandom_range(0, 6);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   // Sends one word; valid stays high without a dip when the next word follows at once.
   task automatic send_word(input logic act, input logic [BIN_W-1:0] bin,
                            input logic [MAG_W-1:0] mag, input logic signed [PH_W-1:0] ph);
      int gap;
      if ($urandom_range(0, 63) == 0)
         req_fast = !req_fast;
      gap = req_fast ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_bin_index <= bin;
      req_magnitude <= mag;
      req_phase <= ph;
      do @(posedge clock); while (!req_ready);
      predict_refinement(act, bin, mag, ph);
   endtask

   // Holds the sender until every result is back, then lets a write word finish too.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_peak_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      threshold_now = (value < THR_MIN) ? THR_MIN : (value > THR_MAX) ? THR_MAX : value;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [MAG_W-1:0] pick_magnitude(input mag_style_type style);
      case (style)
         MAG_TINY:   return MAG_W'($urandom_range(0, 7));
         MAG_TOP:    return MAG_W'(32'hFFFFFF - $urandom_range(0, 255));
         MAG_SCALED: return MAG_W'($urandom >> $urandom_range(8, 31));
         default:    return MAG_W'($urandom_range(0, 24'hFFFFFF));
      endcase
   endfunction

   function automatic logic signed [PH_W-1:0] pick_phase();
      if ($urandom_range(0, 3) == 0)
         return PH_W'($urandom);
      return PH_W'(int'($urandom_range(0, 51472)) - 25736);
   endfunction

   // A bin may be read once it and its in-frame neighbours hold data.
   function automatic bit bin_readable(input int k);
      if (k >= BIN_COUNT)
         return 1'b1;
      return written[k] && (k == 0 || written[k-1]) && (k == BIN_COUNT - 1 || written[k+1]);
   endfunction

   // Words off the main path: dropped writes, out-of-range reads and stray rewrites.
   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: send_word(ACT_WRITE, BIN_W'($urandom_range(BIN_COUNT, 1023)),
                      pick_magnitude(MAG_FULL), pick_phase());
         1: send_word(ACT_READ, BIN_W'($urandom_range(BIN_COUNT, 1023)),
                      pick_magnitude(MAG_FULL), pick_phase());
         default: send_word(ACT_WRITE, BIN_W'($urandom_range(0, BIN_COUNT - 1)),
                            pick_magnitude(mag_style_type'($urandom_range(0, 3))),
                            pick_phase());
      endcase
   endtask

   // Frames written from bin 0 upward with random content, reads mixed in and after.
   task automatic run_frames(input int target);
      int            done_items;
      int            frame_len;
      int            reads;
      int            k;
      mag_style_type style;
      done_items = 0;
      while (done_items < target) begin
         case ($urandom_range(0, 39))
            0:          frame_len = BIN_COUNT;
            1, 2, 3, 4: frame_len = $urandom_range(41, 200);
            default:    frame_len = $urandom_range(3, 40);
         endcase
         style = mag_style_type'($urandom_range(0, 3));
         for (k = 0; k < frame_len; k++) begin
            send_word(ACT_WRITE, BIN_W'(k),
                      pick_magnitude(($urandom_range(0, 7) == 0) ?
                                     mag_style_type'($urandom_range(0, 3)) : style),
                      pick_phase());
            done_items++;
            if (k >= 2 && $urandom_range(0, 3) == 0) begin
               send_word(ACT_READ, BIN_W'(k - 1), pick_magnitude(MAG_FULL), pick_phase());
               done_items++;
            end
            if ($urandom_range(0, 31) == 0)
               send_noise();
         end
         reads = $urandom_range(2, (frame_len < 60) ? frame_len : 60);
         repeat (reads) begin
            k = $urandom_range(0, frame_len - 1);
            if (bin_readable(k)) begin
               send_word(ACT_READ, BIN_W'(k), pick_magnitude(MAG_FULL), pick_phase());
               done_items++;
            end
            if ($urandom_range(0, 15) == 0)
               send_noise();
         end
         if ($urandom_range(0, 7) == 0) begin
            wait_idle();
            if ($urandom_range(0, 1) == 0)
               write_threshold(THR_W'($urandom_range(0, 16'hFFFF)));
         end
      end
   endtask

   // Extremes of the fields, saturating and clamped peaks, ties, edges, dropped bins.
   task automatic test_directed_cases();
      send_word(ACT_WRITE, 10'd0, 24'h000000, -16'sd32768);
      send_word(ACT_WRITE, 10'd1, 24'hFFFFFF, 16'sd32767);
      send_word(ACT_WRITE, 10'd2, 24'hFFFFFE, -16'sd32768);
      send_word(ACT_WRITE, 10'd3, 24'h000000, 16'sd0);
      send_word(ACT_WRITE, 10'd4, 24'hFFFFFD, 16'sd25736);
      send_word(ACT_WRITE, 10'd5, 24'hFFFFFE, -16'sd25736);
      send_word(ACT_WRITE, 10'd6, 24'h000000, 16'sd0);
      send_word(ACT_WRITE, 10'd7, 24'd50, 16'sd100);
      send_word(ACT_WRITE, 10'd8, 24'd50, -16'sd100);
      send_word(ACT_WRITE, 10'd9, 24'd10, 16'sd1);
      send_word(ACT_WRITE, 10'd10, 24'd20, 16'sd2);
      send_word(ACT_WRITE, 10'd11, 24'd0, 16'sd3);
      // Both of these lie past the frame and must leave store and maximum alone.
      send_word(ACT_WRITE, 10'd1023, 24'hFFFFFF, 16'shFFFF);
      send_word(ACT_WRITE, BIN_W'(BIN_COUNT), 24'hFFFFFF, 16'sh7FFF);
      send_word(ACT_WRITE, BIN_W'(BIN_COUNT - 2), 24'd5, 16'sd0);
      send_word(ACT_WRITE, BIN_W'(BIN_COUNT - 1), 24'hFFFFFF, 16'sd32767);
      send_word(ACT_READ, 10'd0, 24'hFFFFFF, 16'shFFFF);
      send_word(ACT_READ, 10'd1, 24'h000000, 16'sd0);
      send_word(ACT_READ, 10'd2, 24'h000000, 16'sd0);
      send_word(ACT_READ, 10'd5, 24'h000000, 16'sd0);
      send_word(ACT_READ, 10'd8, 24'h000000, 16'sd0);
      send_word(ACT_READ, 10'd10, 24'h000000, 16'sd0);
      send_word(ACT_READ, BIN_W'(BIN_COUNT - 1), 24'h000000, 16'sd0);
      send_word(ACT_READ, BIN_W'(BIN_COUNT), 24'h000000, 16'sd0);
      send_word(ACT_READ, 10'd1023, 24'h000000, 16'sd0);
   endtask

   // Each threshold setting, saturated ones included, with bins just at and just over it.
   task automatic test_threshold_settings();
      logic [THR_W-1:0] settings [8];
      longint           top;
      longint           cut;
      settings = '{16'd0, 16'd65, 16'd66, 16'd655, 16'd32768, 16'd32769, 16'hFFFF,
                   16'd0};
      settings[7] = THR_W'($urandom_range(66, 32768));
      foreach (settings[i]) begin
         wait_idle();
         write_threshold(settings[i]);
         top = longint'($urandom_range(24'h100000, 24'hFFFFFF));
         cut = (top * longint'(threshold_now)) >> 16;
         send_word(ACT_WRITE, 10'd0, MAG_W'(top), pick_phase());
         send_word(ACT_WRITE, 10'd1, 24'd0, pick_phase());
         send_word(ACT_WRITE, 10'd2, MAG_W'(cut), pick_phase());
         send_word(ACT_WRITE, 10'd3, 24'd0, pick_phase());
         send_word(ACT_WRITE, 10'd4, MAG_W'(cut + 1), pick_phase());
         send_word(ACT_WRITE, 10'd5, 24'd0, pick_phase());
         send_word(ACT_READ, 10'd2, pick_magnitude(MAG_FULL), pick_phase());
         send_word(ACT_READ, 10'd4, pick_magnitude(MAG_FULL), pick_phase());
         run_frames(40);
      end
   endtask

   task automatic test_random_traffic();
      wait_idle();
      write_threshold(THR_RESET);
      run_frames(1150);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_threshold_settings();
      test_random_traffic();
      wait_idle();
      if (error_count == 0)
         $display("PASS spectral_peak_parabolic_refine");
      else
         $display("FAIL spectral_peak_parabolic_refine");
      $finish;
   end

endmodule

// ===== spectral_peak_parabolic_refine.f =====
sv/spr_pkg.sv
sv/spr_store.sv
sv/spr_div.sv
sv/spectral_peak_parabolic_refine.sv
sv/spr_checker.sv
sim/testbench.sv
